// File: rtl/core/ow_pkg.sv
package ow_pkg;

  // Byte framing
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitIdxW     = $clog2(BitsPerByte);
  localparam int unsigned TimeW       = 11;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 10;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegResetLow     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresenceWait = 3'd1;
  localparam logic [CfgIdxW-1:0] RegResetRecover = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWriteOneLow  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWriteZeroLow = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReadLow      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegReadSample   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSlotLength   = 3'd7;

  // Register values after reset
  localparam logic [9:0] ResetLowDef     = 10'd480;
  localparam logic [9:0] PresenceWaitDef = 10'd70;
  localparam logic [9:0] ResetRecoverDef = 10'd410;
  localparam logic [7:0] WriteOneLowDef  = 8'd6;
  localparam logic [7:0] WriteZeroLowDef = 8'd60;
  localparam logic [7:0] ReadLowDef      = 8'd6;
  localparam logic [7:0] ReadSampleDef   = 8'd9;
  localparam logic [7:0] SlotLengthDef   = 8'd70;
  localparam logic [7:0] SlotLengthMin   = 8'd2;

  typedef enum logic [1:0] {
    OpIdle  = 2'd0,
    OpReset = 2'd1,
    OpWrite = 2'd2,
    OpRead  = 2'd3
  } op_e;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [9:0] presence_wait;
    logic [9:0] reset_recover;
    logic [7:0] write_one_low;
    logic [7:0] write_zero_low;
    logic [7:0] read_low;
    logic [7:0] read_sample;
    logic [7:0] slot_length;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;
  } result_t;

endpackage

// File: rtl/core/ow_cfg.sv
module ow_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ow_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ow_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output ow_pkg::cfg_t                  cfg_o
);
  import ow_pkg::*;

  cfg_t cfg_q;

  // Hold the timing registers, write one per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low      <= ResetLowDef;
      cfg_q.presence_wait  <= PresenceWaitDef;
      cfg_q.reset_recover  <= ResetRecoverDef;
      cfg_q.write_one_low  <= WriteOneLowDef;
      cfg_q.write_zero_low <= WriteZeroLowDef;
      cfg_q.read_low       <= ReadLowDef;
      cfg_q.read_sample    <= ReadSampleDef;
      cfg_q.slot_length    <= SlotLengthDef;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegResetLow:     cfg_q.reset_low      <= cfg_wdata_i;
        RegPresenceWait: cfg_q.presence_wait  <= cfg_wdata_i;
        RegResetRecover: cfg_q.reset_recover  <= cfg_wdata_i;
        RegWriteOneLow:  cfg_q.write_one_low  <= cfg_wdata_i[7:0];
        RegWriteZeroLow: cfg_q.write_zero_low <= cfg_wdata_i[7:0];
        RegReadLow:      cfg_q.read_low       <= cfg_wdata_i[7:0];
        RegReadSample:   cfg_q.read_sample    <= cfg_wdata_i[7:0];
        RegSlotLength:   cfg_q.slot_length    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ow_engine.sv
module ow_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [1:0]      op_i,
  input  logic [7:0]      write_byte_i,
  input  logic            line_level_i,
  input  ow_pkg::cfg_t    cfg_i,
  output ow_pkg::result_t res_o
);
  import ow_pkg::*;

  op_e                op_q, op_d;
  logic [TimeW-1:0]   tc_q, tc_d;
  logic [BitIdxW-1:0] bi_q, bi_d;
  logic [7:0]         sb_q, sb_d;
  logic               pf_q, pf_d;
  logic               sp_q, sp_d;
  logic [7:0]         lr_q, lr_d;

  logic [TimeW-1:0]   tc_next;
  logic [TimeW-1:0]   presence_at;
  logic [7:0]         slen, slen_m1, low_time, sample_at;
  logic [8:0]         sample_sum;
  logic               drive, done, rejected;

  // Slot timing derived from the registers
  always_comb begin
    slen       = (cfg_i.slot_length < SlotLengthMin) ? SlotLengthMin : cfg_i.slot_length;
    slen_m1    = slen - 8'd1;
    sample_sum = {1'b0, cfg_i.read_low} + {1'b0, cfg_i.read_sample};
    sample_at  = (sample_sum > {1'b0, slen_m1}) ? slen_m1 : sample_sum[7:0];
    presence_at = {1'b0, cfg_i.reset_low} + {1'b0, cfg_i.presence_wait};
  end

  // Advance the bus sequencer by one tick
  always_comb begin
    op_d     = op_q;
    tc_d     = tc_q;
    bi_d     = bi_q;
    sb_d     = sb_q;
    pf_d     = pf_q;
    sp_d     = sp_q;
    lr_d     = lr_q;
    drive    = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;
    low_time = 8'd0;
    tc_next  = '0;

    // Start a command, or flag it when one is already running
    if (op_e'(op_i) != OpIdle) begin
      if (op_q != OpIdle) begin
        rejected = 1'b1;
      end else begin
        op_d = op_e'(op_i);
        tc_d = '0;
        bi_d = '0;
        sp_d = 1'b0;
        sb_d = (op_e'(op_i) == OpWrite) ? write_byte_i : 8'd0;
        if (op_e'(op_i) == OpReset) begin
          pf_d = 1'b0;
        end
      end
    end

    tc_next = tc_d + 1'b1;

    if (op_d == OpReset) begin
      if (!sp_d) begin
        drive = (tc_d < {1'b0, cfg_i.reset_low});
        if (tc_d == presence_at) begin
          pf_d = ~line_level_i;
          sp_d = 1'b1;
          tc_d = '0;
        end else begin
          tc_d = tc_next;
        end
      end else begin
        tc_d = tc_next;
        if (tc_next >= {1'b0, cfg_i.reset_recover}) begin
          done = 1'b1;
          op_d = OpIdle;
          tc_d = '0;
          sp_d = 1'b0;
        end
      end
    end else if (op_d != OpIdle) begin
      if (op_d == OpWrite) begin
        low_time = sb_d[bi_d] ? cfg_i.write_one_low : cfg_i.write_zero_low;
      end else begin
        low_time = cfg_i.read_low;
        if (tc_d == {3'b0, sample_at}) begin
          sb_d[bi_d] = line_level_i;
        end
      end
      drive = (tc_d < {3'b0, low_time});
      // Close the slot, and the byte on its last bit
      if (tc_d >= {3'b0, slen_m1}) begin
        tc_d = '0;
        if (bi_d == BitIdxW'(BitsPerByte - 1)) begin
          done = 1'b1;
          if (op_d == OpRead) begin
            lr_d = sb_d;
          end
          op_d = OpIdle;
          bi_d = '0;
        end else begin
          bi_d = bi_d + 1'b1;
        end
      end else begin
        tc_d = tc_next;
      end
    end
  end

  // Hold sequencer state, update on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OpIdle;
      tc_q <= '0;
      bi_q <= '0;
      sb_q <= '0;
      pf_q <= 1'b0;
      sp_q <= 1'b0;
      lr_q <= '0;
    end else if (step_i) begin
      op_q <= op_d;
      tc_q <= tc_d;
      bi_q <= bi_d;
      sb_q <= sb_d;
      pf_q <= pf_d;
      sp_q <= sp_d;
      lr_q <= lr_d;
    end
  end

  assign res_o.drive_low = drive;
  assign res_o.busy_res  = (op_d != OpIdle);
  assign res_o.done_res  = done;
  assign res_o.presence  = pf_d;
  assign res_o.read_byte = lr_d;
  assign res_o.rejected  = rejected;

endmodule

// File: rtl/core/one_wire_bus_master.sv
// One-wire bus master, stepped by tick items of one microsecond each.
// Input channel (in_valid_i/in_ready_o): op_i, write_byte_i, line_level_i.
// Op 0 is a plain tick; ops 1, 2 and 3 start a reset with presence detect,
// a byte write or a byte read, and the starting item is already the first
// tick. A command arriving while busy is ignored and flagged in rejected_o.
// Output channel (out_valid_o/out_ready_i): one result per item with the
// open-drain drive, busy, done, presence and the last read byte.
// The result of an item sits in the output register on the cycle after it
// is accepted. Throughput is one item per cycle while the receiver takes
// results; the sequencer update is one compare-and-advance step between
// the state registers and the output register.
// A stalled receiver holds the output register; a new item is taken only
// when that register is empty or being emptied in the same cycle.
// Timing registers must be written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// only while idle; the block does not enforce it. Reset restores the default
// timings and clears the stored presence and read byte; res_q is not reset.
module one_wire_bus_master (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ow_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ow_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [7:0]                  write_byte_i,
  input  logic                        line_level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        drive_low_o,
  output logic                        busy_res_o,
  output logic                        done_res_o,
  output logic                        presence_o,
  output logic [7:0]                  read_byte_o,
  output logic                        rejected_o
);
  import ow_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ow_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ow_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .op_i         (op_i),
    .write_byte_i (write_byte_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Track output occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result of each accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = res_q.drive_low;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign presence_o  = res_q.presence;
  assign read_byte_o = res_q.read_byte;
  assign rejected_o  = res_q.rejected;

  // An accepted item always shows a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // A finishing operation leaves the master idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // The bus is only pulled low by a running or just finished operation
  a_drive_needs_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o || done_res_o)
    else $error("bus driven low with no operation");

  // A rejected command implies an operation was still running
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o || done_res_o)
    else $error("command rejected while idle");

endmodule
